// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cbd_pkg.sv =====
// types and constants of the chunked body decoder
package cbd_pkg;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_DATA    = 3'd1,
		PH_TERM_A  = 3'd2,
		PH_TERM_B  = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		LS_BEFORE = 2'd0,
		LS_DIGITS = 2'd1,
		LS_SKIP   = 2'd2,
		LS_BAD    = 2'd3
	} line_step_t;

	typedef enum logic [2:0] {
		ST_RUN      = 3'd0,
		ST_DONE     = 3'd1,
		ST_BAD_SIZE = 3'd2,
		ST_BAD_TERM = 3'd3,
		ST_TRAILER  = 3'd4,
		ST_CLOSED   = 3'd5
	} status_t;

	localparam logic       OP_BYTE  = 1'b0;
	localparam logic       OP_CLOSE = 1'b1;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [15:0] TRAILER_LIMIT_RST = 16'd8192;

	localparam int TCOUNT_W = 17;

endpackage

// ===== rtl/core/chunked_body_decoder.sv =====
// chunked transfer body decoder: size lines, payload pass-through, terminators, trailer
//
// usage:
//  - input channel (in_valid, in_stall, op, data_byte): one word per body byte,
//    op high signals the connection closed instead of a byte
//  - output channel (out_valid, out_stall, body_valid, body_byte, status): exactly one
//    word per input word, in order; body_valid marks a decoded payload byte
//  - cfg_we / cfg_wdata write trailer_limit; only write while no word is in flight
//  - an accepted word is held in the input register, which feeds the decode logic;
//    the result settles into the output register once that register can advance
//  - throughput is one word per cycle while out_stall is low; the decoder state is
//    updated in the single cycle in which a word moves from input to output register
//  - when out_stall is high with a full output register, the input register holds
//    and in_stall rises once it is full too; nothing is dropped
//  - arst_n clears the pipeline, returns the decoder to the start of a size line
//    with status running, and sets trailer_limit to 8192
//  - status is sticky: after the first non-running code every further word
//    reports it with body_valid low and body_byte zero
module chunked_body_decoder #(
	parameter int SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        body_valid,
	output logic [7:0]  body_byte,
	output logic [2:0]  status,

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic                  s1_valid_q;
	logic                  op_s1;
	logic [7:0]            byte_s1;

	logic                  out_valid_q;
	logic                  body_valid_s2;
	logic [7:0]            body_byte_s2;
	logic [2:0]            status_s2;

	logic [15:0]           trailer_limit_q;
	cbd_pkg::phase_t       phase_q, phase_d;
	cbd_pkg::line_step_t   step_q, step_d;
	logic                  cr_pending_q, cr_pending_d;
	logic [SIZE_BITS-1:0]  accum_q, accum_d;
	logic [SIZE_BITS-1:0]  bytes_left_q, bytes_left_d;
	logic [cbd_pkg::TCOUNT_W-1:0] tcount_q, tcount_d, tcount_inc;
	cbd_pkg::status_t      final_q, final_d;

	logic                  adv_out, adv_s1, fire;
	logic                  res_valid;
	logic [7:0]            res_byte;
	logic                  is_hex, is_blank, is_cr, is_lf;
	logic [3:0]            hex_val;
	logic [SIZE_BITS-1:0]  bytes_dec;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s1   = !s1_valid_q || adv_out;
	assign fire     = s1_valid_q && adv_out;
	assign in_stall = !adv_s1;

	// hex digit decode of the current byte
	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			hex_val = 4'(byte_s1 - 8'h30);
		end else if (byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			hex_val = 4'(byte_s1 - 8'h57);
		end else if (byte_s1 >= 8'h41 && byte_s1 <= 8'h46) begin
			hex_val = 4'(byte_s1 - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign is_blank   = (byte_s1 == cbd_pkg::CH_SP) || (byte_s1 == cbd_pkg::CH_TAB);
	assign is_cr      = (byte_s1 == cbd_pkg::CH_CR);
	assign is_lf      = (byte_s1 == cbd_pkg::CH_LF);
	assign bytes_dec  = bytes_left_q - SIZE_BITS'(1);
	// saturates one past the widest limit
	assign tcount_inc = tcount_q[cbd_pkg::TCOUNT_W-1] ? tcount_q
		: tcount_q + cbd_pkg::TCOUNT_W'(1);

	always_comb begin
		phase_d      = phase_q;
		step_d       = step_q;
		cr_pending_d = cr_pending_q;
		accum_d      = accum_q;
		bytes_left_d = bytes_left_q;
		tcount_d     = tcount_q;
		final_d      = final_q;
		res_valid    = 1'b0;
		res_byte     = 8'd0;
		if (final_q == cbd_pkg::ST_RUN) begin
			if (op_s1 == cbd_pkg::OP_CLOSE) begin
				final_d = cbd_pkg::ST_CLOSED;
			end else begin
				unique case (phase_q)
					cbd_pkg::PH_SIZE: begin
						if (cr_pending_q && is_lf) begin
							if (step_q == cbd_pkg::LS_BEFORE || step_q == cbd_pkg::LS_BAD) begin
								final_d = cbd_pkg::ST_BAD_SIZE;
							end else begin
								cr_pending_d = 1'b0;
								if (accum_q == '0) begin
									phase_d  = cbd_pkg::PH_TRAILER;
									tcount_d = '0;
								end else begin
									bytes_left_d = accum_q;
									phase_d      = cbd_pkg::PH_DATA;
								end
							end
						end else if (cr_pending_q) begin
							// lone cr acts as a non-digit, the new byte then falls in skip or bad
							cr_pending_d = is_cr;
							if (step_q == cbd_pkg::LS_BEFORE) begin
								step_d = cbd_pkg::LS_BAD;
							end else if (step_q == cbd_pkg::LS_DIGITS) begin
								step_d = cbd_pkg::LS_SKIP;
							end
						end else if (is_cr) begin
							cr_pending_d = 1'b1;
						end else begin
							unique case (step_q)
								cbd_pkg::LS_BEFORE: begin
									if (!is_blank) begin
										if (is_hex) begin
											step_d  = cbd_pkg::LS_DIGITS;
											accum_d = {{(SIZE_BITS-4){1'b0}}, hex_val};
										end else begin
											step_d = cbd_pkg::LS_BAD;
										end
									end
								end
								cbd_pkg::LS_DIGITS: begin
									if (!is_hex) begin
										step_d = cbd_pkg::LS_SKIP;
									end else if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
										step_d = cbd_pkg::LS_BAD;
									end else begin
										accum_d = {accum_q[SIZE_BITS-5:0], hex_val};
									end
								end
								default: begin
								end
							endcase
						end
					end
					cbd_pkg::PH_DATA: begin
						res_valid    = 1'b1;
						res_byte     = byte_s1;
						bytes_left_d = bytes_dec;
						if (bytes_dec == '0) begin
							phase_d = cbd_pkg::PH_TERM_A;
						end
					end
					cbd_pkg::PH_TERM_A: begin
						cr_pending_d = is_cr;
						phase_d      = cbd_pkg::PH_TERM_B;
					end
					cbd_pkg::PH_TERM_B: begin
						if (cr_pending_q && is_lf) begin
							phase_d      = cbd_pkg::PH_SIZE;
							step_d       = cbd_pkg::LS_BEFORE;
							cr_pending_d = 1'b0;
							accum_d      = '0;
						end else begin
							final_d = cbd_pkg::ST_BAD_TERM;
						end
					end
					cbd_pkg::PH_TRAILER: begin
						if (cr_pending_q && is_lf) begin
							final_d = cbd_pkg::ST_DONE;
						end else begin
							cr_pending_d = is_cr;
							tcount_d     = tcount_inc;
							if (tcount_inc > {1'b0, trailer_limit_q}) begin
								final_d = cbd_pkg::ST_TRAILER;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// control and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q      <= 1'b0;
			out_valid_q     <= 1'b0;
			trailer_limit_q <= cbd_pkg::TRAILER_LIMIT_RST;
			phase_q         <= cbd_pkg::PH_SIZE;
			step_q          <= cbd_pkg::LS_BEFORE;
			cr_pending_q    <= 1'b0;
			accum_q         <= '0;
			bytes_left_q    <= '0;
			tcount_q        <= '0;
			final_q         <= cbd_pkg::ST_RUN;
		end else begin
			if (adv_s1) begin
				s1_valid_q <= in_valid;
			end
			if (adv_out) begin
				out_valid_q <= s1_valid_q;
			end
			if (cfg_we) begin
				trailer_limit_q <= cfg_wdata;
			end
			if (fire) begin
				phase_q      <= phase_d;
				step_q       <= step_d;
				cr_pending_q <= cr_pending_d;
				accum_q      <= accum_d;
				bytes_left_q <= bytes_left_d;
				tcount_q     <= tcount_d;
				final_q      <= final_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
		if (fire) begin
			body_valid_s2 <= res_valid;
			body_byte_s2  <= res_byte;
			status_s2     <= final_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign body_valid = body_valid_s2;
	assign body_byte  = body_byte_s2;
	assign status     = status_s2;

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_data_only_running, out_valid_q && body_valid_s2, status_s2 == cbd_pkg::ST_RUN, "payload word with non-running status")
	`ASSERT_NEXT(a_status_sticky, final_q != cbd_pkg::ST_RUN, final_q == $past(final_q), "final status changed after end")
	`ASSERT_IMPL(a_data_has_bytes, phase_q == cbd_pkg::PH_DATA, bytes_left_q != '0, "data phase with no bytes left")
	`ASSERT_IMPL(a_no_stall_when_empty, !s1_valid_q, !in_stall, "input stalled with empty input register")

endmodule

// ===== tb/tb_chunked_body_decoder.sv =====
// testbench for the chunked body decoder: random chunk streams checked against a predictor
`timescale 1ns / 100ps

module tb_chunked_body_decoder;

	localparam int SIZE_BITS = 32;

	// ways the stream is brought to its end
	localparam int END_DONE     = 0;
	localparam int END_BAD_SIZE = 1;
	localparam int END_BAD_TERM = 2;
	localparam int END_TRAILER  = 3;
	localparam int END_CLOSED   = 4;

	typedef struct packed {
		logic             bvalid;
		logic [7:0]       bbyte;
		cbd_pkg::status_t stat;
	} decoded_t;

	class decode_scoreboard;
		cbd_pkg::phase_t        ph = cbd_pkg::PH_SIZE;
		cbd_pkg::line_step_t    ls = cbd_pkg::LS_BEFORE;
		bit                     cr_pend = 1'b0;
		logic [SIZE_BITS-1:0]   accum = '0;
		logic [SIZE_BITS-1:0]   left = '0;
		int unsigned            tcount = 0;
		cbd_pkg::status_t       fstat = cbd_pkg::ST_RUN;
		logic [15:0]            trailer_limit = cbd_pkg::TRAILER_LIMIT_RST;
		decoded_t               expected_words[$];
		int                     errors = 0;
		int                     checked = 0;

		function int hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			return -1;
		endfunction

		function void start_line();
			ls = cbd_pkg::LS_BEFORE;
			cr_pend = 1'b0;
			accum = '0;
		endfunction

		// one content byte of a size line, never the line feed that ends it
		function void line_char(logic [7:0] c);
			int d;
			d = hex_digit(c);
			case (ls)
				cbd_pkg::LS_BEFORE: begin
					if (c != cbd_pkg::CH_SP && c != cbd_pkg::CH_TAB) begin
						if (d < 0) begin
							ls = cbd_pkg::LS_BAD;
						end else begin
							ls = cbd_pkg::LS_DIGITS;
							accum = SIZE_BITS'(d);
						end
					end
				end
				cbd_pkg::LS_DIGITS: begin
					if (d < 0)
						ls = cbd_pkg::LS_SKIP;
					else if (accum[SIZE_BITS-1 -: 4] != 0)
						ls = cbd_pkg::LS_BAD;
					else
						accum = {accum[SIZE_BITS-5:0], d[3:0]};
				end
				default: ;
			endcase
		endfunction

		function void size_byte(logic [7:0] b);
			if (cr_pend && b == cbd_pkg::CH_LF) begin
				if (ls == cbd_pkg::LS_BEFORE || ls == cbd_pkg::LS_BAD) begin
					fstat = cbd_pkg::ST_BAD_SIZE;
				end else if (accum == 0) begin
					ph = cbd_pkg::PH_TRAILER;
					tcount = 0;
					cr_pend = 1'b0;
				end else begin
					left = accum;
					ph = cbd_pkg::PH_DATA;
					cr_pend = 1'b0;
				end
				return;
			end
			if (cr_pend)
				line_char(cbd_pkg::CH_CR);
			cr_pend = (b == cbd_pkg::CH_CR);
			if (b != cbd_pkg::CH_CR)
				line_char(b);
		endfunction

		function void note_word(logic o, logic [7:0] b);
			decoded_t w;
			w.bvalid = 1'b0;
			w.bbyte = 8'h00;
			if (fstat == cbd_pkg::ST_RUN) begin
				if (o == cbd_pkg::OP_CLOSE) begin
					fstat = cbd_pkg::ST_CLOSED;
				end else begin
					case (ph)
						cbd_pkg::PH_SIZE: size_byte(b);
						cbd_pkg::PH_DATA: begin
							w.bvalid = 1'b1;
							w.bbyte = b;
							left = left - SIZE_BITS'(1);
							if (left == 0)
								ph = cbd_pkg::PH_TERM_A;
						end
						cbd_pkg::PH_TERM_A: begin
							cr_pend = (b == cbd_pkg::CH_CR);
							ph = cbd_pkg::PH_TERM_B;
						end
						cbd_pkg::PH_TERM_B: begin
							if (cr_pend && b == cbd_pkg::CH_LF) begin
								ph = cbd_pkg::PH_SIZE;
								start_line();
							end else begin
								fstat = cbd_pkg::ST_BAD_TERM;
							end
						end
						cbd_pkg::PH_TRAILER: begin
							if (cr_pend && b == cbd_pkg::CH_LF) begin
								fstat = cbd_pkg::ST_DONE;
							end else begin
								cr_pend = (b == cbd_pkg::CH_CR);
								if (tcount <= 32'hFFFF)
									tcount++;
								if (tcount > trailer_limit)
									fstat = cbd_pkg::ST_TRAILER;
							end
						end
						default: ;
					endcase
				end
			end
			w.stat = fstat;
			expected_words = {expected_words, w};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("MISMATCH: %s", msg);
		endtask

		task check_word(logic bv, logic [7:0] bb, logic [2:0] st);
			decoded_t w;
			checked++;
			if (expected_words.size() == 0) begin
				report($sformatf("word %0d arrived with nothing expected", checked));
				return;
			end
			w = expected_words.pop_front();
			if (bv !== w.bvalid)
				report($sformatf("word %0d: body_valid %b, expected %b", checked, bv, w.bvalid));
			if (bb !== w.bbyte)
				report($sformatf("word %0d: body_byte %h, expected %h", checked, bb, w.bbyte));
			if (st !== w.stat)
				report($sformatf("word %0d: status %0d, expected %0d", checked, st, w.stat));
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = cbd_pkg::OP_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        body_valid;
	logic [7:0]  body_byte;
	logic [2:0]  status;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;

	decode_scoreboard sb;
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int end_kind = END_DONE;

	chunked_body_decoder #(
		.SIZE_BITS(SIZE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.body_valid(body_valid),
		.body_byte(body_byte),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(body_valid, body_byte, status);
	end

	// called at a falling edge; returns at the falling edge after acceptance with valid still high
	task automatic send_word(logic o, logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(o, b);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_word(cbd_pkg::OP_BYTE, b);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10)
			return 8'("0" + n);
		return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
	endfunction

	// any byte but a carriage return, so it cannot start a line end
	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		b = rand_byte();
		return (b == cbd_pkg::CH_CR) ? "x" : b;
	endfunction

	task automatic send_size_line(logic [31:0] size);
		int nd;
		logic [7:0] b;
		repeat ($urandom_range(0, 2))
			send_byte($urandom_range(0, 1) ? cbd_pkg::CH_SP : cbd_pkg::CH_TAB);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) send_byte("0");
		nd = 1;
		while (nd < 8 && (size >> (4 * nd)) != 0)
			nd++;
		for (int i = nd - 1; i >= 0; i--)
			send_byte(hex_char(size[4*i +: 4]));
		case ($urandom_range(0, 3))
			1: begin
				send_byte(";");
				repeat ($urandom_range(0, 6)) send_byte(junk_byte());
			end
			2: begin
				send_byte(cbd_pkg::CH_SP);
				repeat ($urandom_range(0, 4)) send_byte(junk_byte());
			end
			3: begin
				// lone carriage return inside the line
				send_byte(cbd_pkg::CH_CR);
				b = junk_byte();
				send_byte((b == cbd_pkg::CH_LF) ? "y" : b);
			end
			default: ;
		endcase
		send_text("\015\n");
	endtask

	task automatic send_chunk(int unsigned size);
		send_size_line(size);
		repeat (size) send_byte(rand_byte());
		send_text("\015\n");
	endtask

	task automatic send_chunks_until(int target);
		while (words_sent < target)
			send_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_trailer_limit(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.trailer_limit = v;
	endtask

	task automatic finish_stream(int kind, int tlen);
		logic [7:0] a;
		logic [7:0] b;
		int n;
		case (kind)
			END_DONE: begin
				send_size_line(0);
				repeat (tlen) send_byte(junk_byte());
				send_text("\015\n");
			end
			END_BAD_SIZE: begin
				case ($urandom_range(0, 5))
					0: send_text("-5\015\n");
					1: send_text(";x\015\n");
					2: send_text("\015\n");
					3: send_text(" \t\015\n");
					4: send_text("z\015\n");
					default: begin
						// nine significant digits do not fit in the size field
						send_byte("1");
						repeat (8) send_byte(hex_char(4'($urandom_range(0, 15))));
						send_text("\015\n");
					end
				endcase
			end
			END_BAD_TERM: begin
				n = $urandom_range(1, 4);
				send_size_line(n);
				repeat (n) send_byte(rand_byte());
				a = rand_byte();
				b = rand_byte();
				if (a == cbd_pkg::CH_CR && b == cbd_pkg::CH_LF)
					b = cbd_pkg::CH_CR;
				send_byte(a);
				send_byte(b);
			end
			END_TRAILER: begin
				send_size_line(0);
				repeat (sb.trailer_limit + 1) send_byte(junk_byte());
			end
			default: begin
				n = $urandom_range(2, 5);
				case ($urandom_range(0, 4))
					0: send_text(" a");
					1: begin
						send_size_line(n);
						repeat ($urandom_range(1, n - 1)) send_byte(rand_byte());
					end
					2: begin
						send_size_line(n);
						repeat (n) send_byte(rand_byte());
					end
					3: begin
						send_size_line(n);
						repeat (n) send_byte(rand_byte());
						send_byte(cbd_pkg::CH_CR);
					end
					default: send_size_line(0);
				endcase
				send_word(cbd_pkg::OP_CLOSE, rand_byte());
			end
		endcase
	endtask

	initial begin
		#4ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int tlen;
		logic [15:0] limit;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no idling: blanks, extension, lone carriage return, payload extremes
		send_text(" \t1;x\015\n");
		send_byte(8'hFF);
		send_text("\015\n");
		send_text("1\015Z\015\n");
		send_byte(8'h00);
		send_text("\015\n");
		send_chunks_until(440);

		wait_idle();
		write_trailer_limit(16'hFFFF);
		idle_pct = 67;
		send_chunks_until(880);

		wait_idle();
		write_trailer_limit(16'h0000);
		idle_pct = 0;
		stall_pct = 67;
		send_chunks_until(1320);

		wait_idle();
		end_kind = $urandom_range(END_DONE, END_CLOSED);
		tlen = $urandom_range(0, 12);
		if (end_kind == END_DONE)
			limit = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(tlen + 1, 40));
		else if (end_kind == END_TRAILER)
			limit = 16'($urandom_range(0, 24));
		else
			limit = 16'($urandom_range(0, 65535));
		write_trailer_limit(limit);
		idle_pct = 13;
		stall_pct = 13;
		send_chunks_until(1700);
		finish_stream(end_kind, tlen);
		// the status is sticky from here on
		repeat (32) send_word(1'($urandom_range(0, 1)), rand_byte());

		wait_idle();
		if (sb.expected_words.size() != 0)
			sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));
		$display("covered %0d words and %0d results over four idle and stall mixes",
			words_sent, sb.checked);
		$display("stream ended in way %0d with status %0d, trailer limit %0d",
			end_kind, sb.fstat, sb.trailer_limit);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== chunked_body_decoder.f =====
+incdir+rtl/core
rtl/core/cbd_pkg.sv
rtl/core/chunked_body_decoder.sv
tb/tb_chunked_body_decoder.sv
